[design/ipbl_pkg.sv]
// ipbl_pkg: types, constants and match helpers for the IPv4 block list engine.
// No dependencies; imported by every module under design/.
package ipbl_pkg;

  localparam int MANUAL_DEPTH = 64;
  localparam int AUTO_DEPTH   = 64;
  localparam int ADDR_BITS    = 32;

  localparam int MAN_AW     = (MANUAL_DEPTH > 1) ? $clog2(MANUAL_DEPTH) : 1;
  localparam int MAN_CNT_W  = $clog2(MANUAL_DEPTH + 1);
  localparam int AUTO_AW    = (AUTO_DEPTH > 1) ? $clog2(AUTO_DEPTH) : 1;
  localparam int AUTO_SW    = AUTO_AW + 1;
  localparam int AUTO_CNT_W = $clog2(AUTO_DEPTH + 1);
  localparam int SCAN_W     = (MAN_CNT_W > AUTO_CNT_W) ? MAN_CNT_W : AUTO_CNT_W;
  localparam int CFG_W      = 7;

  // operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_ADD    = 2'd2;

  // manual entry kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_EXACT = 2'd1;
  localparam logic [1:0] KIND_CIDR  = 2'd2;
  localparam logic [1:0] KIND_RANGE = 2'd3;

  // match source
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_MANUAL = 2'd1;
  localparam logic [1:0] SRC_AUTO   = 2'd2;

  // add status
  localparam logic [2:0] ADD_NONE     = 3'd0;
  localparam logic [2:0] ADD_DONE     = 3'd1;
  localparam logic [2:0] ADD_EVICTED  = 3'd2;
  localparam logic [2:0] ADD_IN_MAN   = 3'd3;
  localparam logic [2:0] ADD_IN_AUTO  = 3'd4;

  typedef struct packed {
    logic [1:0]           operation;
    logic [5:0]           entry_index;
    logic [1:0]           entry_kind;
    logic [ADDR_BITS-1:0] ip_address;
    logic [ADDR_BITS-1:0] second_value;
  } in_beat_t;

  typedef struct packed {
    logic       listed;
    logic [1:0] match_source;
    logic [2:0] add_status;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] first;
    logic [ADDR_BITS-1:0] second;
  } man_entry_t;

  // Manual entry compare. exact_only restricts to exact entries (auto-add dup check).
  function automatic logic entry_hit(man_entry_t e, logic [ADDR_BITS-1:0] addr,
                                     logic exact_only);
    logic [ADDR_BITS-1:0] mask;
    logic                 ge_a, le_a, ge_b, le_b, swap;
    logic                 hit;
    mask = ~({ADDR_BITS{1'b1}} >> e.second[5:0]);
    ge_a = addr >= e.first;
    le_a = addr <= e.first;
    ge_b = addr >= e.second;
    le_b = addr <= e.second;
    swap = e.first > e.second;
    hit  = 1'b0;
    case (e.kind)
      KIND_EXACT: hit = (addr == e.first);
      KIND_CIDR:  hit = !exact_only && (e.second <= ADDR_BITS) &&
                        ((addr & mask) == (e.first & mask));
      KIND_RANGE: hit = !exact_only && (swap ? (ge_b && le_a) : (ge_a && le_b));
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

  // (a + b) mod AUTO_DEPTH for a, b below AUTO_DEPTH
  function automatic logic [AUTO_AW-1:0] auto_wrap(logic [AUTO_AW-1:0] a,
                                                   logic [AUTO_AW-1:0] b);
    logic [AUTO_SW-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= AUTO_SW'(AUTO_DEPTH)) s = s - AUTO_SW'(AUTO_DEPTH);
    return s[AUTO_AW-1:0];
  endfunction

endpackage

[design/ip_block_list_engine.sv]
// ip_block_list_engine: IPv4 block list, manual table plus automatic FIFO.
// Manual write / unknown op: no scan, the result goes straight to output. Lookup and
// auto-add: a scan of the manual entries in use (n = in-use register, saturated), then,
// unless it hits, a scan of the live auto entries in the FIFO; one item at a time.
// Each scan reads one entry per cycle from a single memory read port.
// Reset: async active low; manual table reads empty, FIFO empty, register zero.
module ip_block_list_engine import ipbl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_beat_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_beat_t        out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MSCAN = 4'b0010,
    ST_ASCAN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       in_use_q;
  logic [SCAN_W-1:0]      n_active;
  logic [1:0]             op_q, op_d;
  logic [ADDR_BITS-1:0]   addr_q, addr_d;
  logic [SCAN_W-1:0]      cnt_q, cnt_d;
  logic                   hit_q, hit_d;
  logic                   rd_pend_q, rd_pend_d;
  out_beat_t              res_q, res_d;
  out_beat_t              out_q;
  logic                   out_valid_q;
  logic [AUTO_AW-1:0]     oldest_q, oldest_d;
  logic [AUTO_CNT_W-1:0]  count_q, count_d;

  logic                   in_acc;
  logic                   man_we, man_re, auto_we, auto_re;
  man_entry_t             man_wdata, man_rdata;
  logic [AUTO_AW-1:0]     auto_waddr, auto_raddr;
  logic [ADDR_BITS-1:0]   auto_rdata;
  logic                   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // register value above depth saturates
  always_comb begin
    if (32'(in_use_q) > MANUAL_DEPTH) n_active = SCAN_W'(MANUAL_DEPTH);
    else                              n_active = SCAN_W'(in_use_q);
  end

  assign man_we    = in_acc && (in_data_i.operation == OP_WRITE) &&
                     (32'(in_data_i.entry_index) < MANUAL_DEPTH);
  assign man_wdata = '{kind:   in_data_i.entry_kind,
                       first:  in_data_i.ip_address,
                       second: in_data_i.second_value};
  assign man_re     = (state_q == ST_MSCAN) && (cnt_q < n_active) && !hit_q;
  assign auto_re    = (state_q == ST_ASCAN) && (cnt_q < SCAN_W'(count_q)) && !hit_q;
  assign auto_raddr = auto_wrap(oldest_q, cnt_q[AUTO_AW-1:0]);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    hit_d      = hit_q;
    rd_pend_d  = 1'b0;
    res_d      = res_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    auto_we    = 1'b0;
    auto_waddr = oldest_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d   = in_data_i.operation;
          addr_d = in_data_i.ip_address;
          cnt_d  = '0;
          hit_d  = 1'b0;
          res_d  = '0;
          if (in_data_i.operation == OP_LOOKUP || in_data_i.operation == OP_ADD) begin
            state_d = ST_MSCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MSCAN: begin
        rd_pend_d = man_re;
        if (man_re) cnt_d = cnt_q + SCAN_W'(1);
        if (rd_pend_q && entry_hit(man_rdata, addr_q, op_q == OP_ADD)) hit_d = 1'b1;
        if (!man_re && !rd_pend_q) begin
          if (hit_q) begin
            if (op_q == OP_ADD) begin
              res_d.add_status = ADD_IN_MAN;
            end else begin
              res_d.listed       = 1'b1;
              res_d.match_source = SRC_MANUAL;
            end
            state_d = ST_DONE;
          end else begin
            cnt_d   = '0;
            state_d = ST_ASCAN;
          end
        end
      end
      ST_ASCAN: begin
        rd_pend_d = auto_re;
        if (auto_re) cnt_d = cnt_q + SCAN_W'(1);
        if (rd_pend_q && (auto_rdata == addr_q)) hit_d = 1'b1;
        if (!auto_re && !rd_pend_q) begin
          state_d = ST_DONE;
          if (op_q == OP_LOOKUP) begin
            if (hit_q) begin
              res_d.listed       = 1'b1;
              res_d.match_source = SRC_AUTO;
            end
          end else if (hit_q) begin
            res_d.add_status = ADD_IN_AUTO;
          end else if (count_q == AUTO_CNT_W'(AUTO_DEPTH)) begin
            // full: overwrite oldest
            auto_we          = 1'b1;
            auto_waddr       = oldest_q;
            oldest_d         = auto_wrap(oldest_q, AUTO_AW'(1));
            res_d.add_status = ADD_EVICTED;
          end else begin
            auto_we          = 1'b1;
            auto_waddr       = auto_wrap(oldest_q, count_q[AUTO_AW-1:0]);
            count_d          = count_q + AUTO_CNT_W'(1);
            res_d.add_status = ADD_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_use_q    <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      oldest_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      hit_q     <= hit_d;
      rd_pend_q <= rd_pend_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      if (cfg_we_i) in_use_q <= cfg_wdata_i;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    addr_q <= addr_d;
    res_q  <= res_d;
    if (state_q == ST_DONE && out_free) out_q <= res_q;
  end

  ipbl_man_tbl u_man_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (man_we),
    .waddr_i (MAN_AW'(in_data_i.entry_index)),
    .wdata_i (man_wdata),
    .re_i    (man_re),
    .raddr_i (cnt_q[MAN_AW-1:0]),
    .rdata_o (man_rdata)
  );

  ipbl_auto_mem u_auto_mem (
    .clk_i   (clk_i),
    .we_i    (auto_we),
    .waddr_i (auto_waddr),
    .wdata_i (addr_q),
    .re_i    (auto_re),
    .raddr_i (auto_raddr),
    .rdata_o (auto_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= AUTO_CNT_W'(AUTO_DEPTH))
    else $error("auto fifo count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_MSCAN || state_q == ST_ASCAN))
    else $error("read data pending outside a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    auto_we |-> (state_q == ST_ASCAN && op_q == OP_ADD && !hit_q))
    else $error("fifo write without a fresh auto-add");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_o)
    else $error("finished result not presented");

endmodule

[design/ipbl_man_tbl.sv]
// ipbl_man_tbl: manual table memory, registered read.
// Kind is qualified by per-slot valid bits cleared at reset. Uses ipbl_pkg.
module ipbl_man_tbl import ipbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [MAN_AW-1:0] waddr_i,
  input  man_entry_t        wdata_i,
  input  logic              re_i,
  input  logic [MAN_AW-1:0] raddr_i,
  output man_entry_t        rdata_o
);

  man_entry_t                mem [MANUAL_DEPTH];
  logic [MANUAL_DEPTH-1:0]   valid_q;
  man_entry_t                rd_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (re_i) begin
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // unwritten slot reads as empty
  always_comb begin
    rdata_o = rd_q;
    if (!rd_vld_q) rdata_o.kind = KIND_EMPTY;
  end

endmodule

[design/ipbl_auto_mem.sv]
// ipbl_auto_mem: address store of the automatic FIFO, registered read.
// Uses ipbl_pkg for depth and widths.
module ipbl_auto_mem import ipbl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AUTO_AW-1:0]   waddr_i,
  input  logic [ADDR_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AUTO_AW-1:0]   raddr_i,
  output logic [ADDR_BITS-1:0] rdata_o
);

  logic [ADDR_BITS-1:0] mem [AUTO_DEPTH];
  logic [ADDR_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule
